// ===== hw/rtl/sse_pkg.sv =====
// Package: shared types, constants and the order compare of the selection sort engine.
package sse_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_SWAP,
    ST_EMIT
  } state_t;

  // True when cand should replace best under the selected order (strict).
  function automatic logic beats(input value_t best, input value_t cand, input logic desc);
    logic result;
    if (desc) begin
      result = best < cand;
    end else begin
      result = best > cand;
    end
    return result;
  endfunction

endpackage

// ===== hw/rtl/sse_if.sv =====
// Interfaces: input, result and configuration channels of the selection sort engine.
interface sse_in_if;
  logic            valid;
  logic            ready;
  sse_pkg::value_t item_value;
  logic            last_item;

  modport source (output valid, output item_value, output last_item, input ready);
  modport sink   (input valid, input item_value, input last_item, output ready);
endinterface

interface sse_out_if;
  logic            valid;
  logic            ready;
  sse_pkg::value_t sorted_value;
  logic            last_result;
  logic            overflow;

  modport source (output valid, output sorted_value, output last_result, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_result, input overflow,
                  output ready);
endinterface

interface sse_cfg_if;
  logic valid;
  logic ready;
  logic descending;

  modport source (output valid, output descending, input ready);
  modport sink   (input valid, input descending, output ready);
endinterface

// ===== hw/rtl/sse_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/selection_sort_engine.sv =====
// Top level: selection sort engine over a list of signed 32-bit words held in one RAM.
//
// The engine collects a list one word per cycle (the word flagged last_item closes it), up
// to MAX_ELEMENTS entries; further words are dropped and the overflow flag of that list is
// raised on every result. The order (descending bit) is sampled when the last word arrives.
// The list is then sorted by selection sort: pass p reads entries p..N-1 from the element
// RAM through its single read port, one entry and one strict compare per cycle, keeps the
// winner, writes the old entry p into the winner's slot and hands the winner straight to
// the result register. The next list is taken as soon as the final result sits in the
// output register. No input word is taken while a list is sorted.
module selection_sort_engine #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic      clk,
  input  logic      rst,
  sse_in_if.sink    in,
  sse_out_if.source out,
  sse_cfg_if.sink   cfg
);

  localparam int unsigned IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_ELEMENTS);

  sse_pkg::state_t state, state_next;

  // Control and datapath registers
  logic            descending;     // configuration register
  logic            desc_q;         // order frozen for the current list
  logic [CW-1:0]   count;          // words held
  logic            dropped;
  logic [CW-1:0]   pos;            // head of the unsorted tail
  logic [CW-1:0]   rd_idx;         // next entry to read
  logic            dv;             // read data valid this cycle
  logic [IW-1:0]   idx_q;          // entry whose data arrives this cycle
  sse_pkg::value_t best;
  sse_pkg::value_t pos_val;
  logic [IW-1:0]   pick;

  logic            out_valid;
  sse_pkg::value_t out_value;
  logic            out_last;
  logic            out_ovf;

  // Combinational controls
  logic            in_fire;
  logic            full;
  logic            issue;
  logic            scan_done;
  logic            first_rd;
  logic            take;
  logic            emit;
  logic            list_end;
  logic [CW-1:0]   count_m1;
  sse_pkg::value_t rd_data;

  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  sse_pkg::value_t ram_wdata;

  assign cfg.ready = 1'b1;

  assign count_m1  = count - CW'(1);
  assign full      = (count == COUNT_MAX);
  assign in_fire   = in.valid && in.ready;
  assign issue     = (state == sse_pkg::ST_SCAN) && (rd_idx < count);
  assign first_rd  = (idx_q == pos[IW-1:0]);
  assign take      = dv && (first_rd || sse_pkg::beats(best, rd_data, desc_q));
  assign scan_done = dv && ({1'b0, idx_q} == {1'b0, count_m1[IW-1:0]}) && (count_m1 < COUNT_MAX);
  assign list_end  = (pos == count_m1);
  assign emit      = (state == sse_pkg::ST_EMIT) && (!out_valid || out.ready);

  // Write port: collect words while loading, move the old head into the winner's slot on swap
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[IW-1:0];
    ram_wdata = in.item_value;
    if (state == sse_pkg::ST_LOAD) begin
      ram_we = in_fire && !full;
    end else if (state == sse_pkg::ST_SWAP) begin
      ram_we    = 1'b1;
      ram_waddr = pick;
      ram_wdata = pos_val;
    end
  end

  sse_ram #(
    .WIDTH (sse_pkg::VALUE_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (rd_idx[IW-1:0]),
    .rdata (rd_data)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sse_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_next = state;
    in.ready   = 1'b0;
    case (state)
      sse_pkg::ST_LOAD: begin
        in.ready = 1'b1;
        // Ready is high throughout loading, so valid alone marks a taken word
        if (in.valid && in.last_item) begin
          state_next = sse_pkg::ST_SCAN;
        end
      end
      sse_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = sse_pkg::ST_SWAP;
        end
      end
      sse_pkg::ST_SWAP: begin
        state_next = sse_pkg::ST_EMIT;
      end
      sse_pkg::ST_EMIT: begin
        if (emit) begin
          state_next = list_end ? sse_pkg::ST_LOAD : sse_pkg::ST_SCAN;
        end
      end
      default: begin
        state_next = sse_pkg::ST_LOAD;
      end
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      descending <= cfg.descending;
    end
  end

  // Control counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dropped   <= 1'b0;
      pos       <= '0;
      rd_idx    <= '0;
      dv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      dv <= issue;
      if (state == sse_pkg::ST_LOAD && in_fire) begin
        // Store the word, or drop it once the RAM is full
        if (full) begin
          dropped <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
        pos    <= '0;
        rd_idx <= '0;
      end
      if (issue) begin
        rd_idx <= rd_idx + CW'(1);
      end
      if (emit) begin
        if (list_end) begin
          count   <= '0;
          dropped <= 1'b0;
        end
        pos    <= pos + CW'(1);
        rd_idx <= pos + CW'(1);
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_q <= rd_idx[IW-1:0];
    if (state == sse_pkg::ST_LOAD && in_fire && in.last_item) begin
      desc_q <= descending;
    end
    if (dv && first_rd) begin
      pos_val <= rd_data;
    end
    if (take) begin
      best <= rd_data;
      pick <= idx_q;
    end
    if (emit) begin
      out_value <= best;
      out_last  <= list_end;
      out_ovf   <= dropped;
    end
  end

  assign out.valid        = out_valid;
  assign out.sorted_value = out_value;
  assign out.last_result  = out_last;
  assign out.overflow     = out_ovf;

  // The held word count never passes the RAM depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_MAX)
    else $error("word count beyond RAM depth");

  // Read data during a scan always belongs to the unsorted tail
  a_scan_in_tail: assert property (@(posedge clk) disable iff (rst)
    (state == sse_pkg::ST_SCAN && dv) |-> ({1'b0, idx_q} >= {1'b0, pos[IW-1:0]}))
    else $error("scan read outside unsorted tail");

  // A result is loaded only when the output register is free or being emptied
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out.ready) |=> ($stable(out_value) && $stable(out_last)))
    else $error("pending result overwritten");

  // The winner slot written on swap lies inside the current list
  a_swap_in_list: assert property (@(posedge clk) disable iff (rst)
    (state == sse_pkg::ST_SWAP) |-> ({1'b0, pick} < count))
    else $error("swap outside list");

endmodule
